@@ sv/console_line_editor_assert.svh @@
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// same-cycle implication
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/cle_pkg.sv @@
package cle_pkg;

   localparam int LINE_WIDTH_DEF = 32;

   localparam logic OP_CHAR    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] KIND_ECHO   = 2'd0;
   localparam logic [1:0] KIND_LINE   = 2'd1;
   localparam logic [1:0] KIND_NOTICE = 2'd2;

   localparam logic [7:0] CHR_BS       = 8'h08;
   localparam logic [7:0] CHR_LF       = 8'h0A;
   localparam logic [7:0] CHR_CR       = 8'h0D;
   localparam logic [7:0] CHR_ESC      = 8'h1B;
   localparam logic [7:0] CHR_SPACE    = 8'h20;
   localparam logic [7:0] CHR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHR_A        = 8'h41;
   localparam logic [7:0] CHR_B        = 8'h42;
   localparam logic [7:0] CHR_C        = 8'h43;
   localparam logic [7:0] CHR_D        = 8'h44;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

endpackage

@@ sv/cle_ram.sv @@
module cle_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 32)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/console_line_editor.sv @@
// channel    dir   handshake              payload
// request    in    req_valid / req_ready  req (req_type)
// response   out   rsp_valid / rsp_ready  rsp (rsp_type)
//
// A request is taken only while the sequencer is idle.
// A character is taken while idle, and its responses, if any, then follow;
// a commit streams the stored line from the line RAM read port, one byte a
// cycle while the response channel does not stall. A release only clears the pending flag.
// Reset clears the index, the escape and pending flags and the sequencer;
// the line RAM is not cleared. A stalled response holds the sequencer.
module console_line_editor
   import cle_pkg::*;
   #(parameter int LINE_WIDTH = LINE_WIDTH_DEF)
   (input  logic    clock,
    input  logic    reset,
    input  logic    req_valid,
    output logic    req_ready,
    input  req_type req,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output rsp_type rsp);

   localparam int IDX_W  = $clog2(LINE_WIDTH + 1);
   localparam int ADDR_W = $clog2(LINE_WIDTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ECHO   = 2'd1;
   localparam logic [1:0] ST_LINE   = 2'd2;
   localparam logic [1:0] ST_NOTICE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  wi_ff, wi_in;
   logic              esc_ff, esc_in;
   logic              brk_ff, brk_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] line_last_ff, line_last_in;
   logic [1:0]        pos_ff, pos_in;
   logic              bs_ff, bs_in;
   logic [7:0]        echo_byte_ff, echo_byte_in;
   logic              notice_ff, notice_in;

   logic [7:0]        c;
   logic              is_print, is_bs, is_term, is_esc, is_arrow;
   logic              store_en, has_echo, commit, ovf;
   logic [IDX_W-1:0]  wi_inc, wi_a, wi_nx;
   logic              esc_nx, brk_nx;
   logic              out_free;
   logic [1:0]        echo_last;
   logic              ram_we;
   logic [7:0]        ram_rd;

   assign c        = req.rx_byte;
   assign is_print = !c[7] && (c[6:5] != 2'b00);
   assign is_bs    = (c == CHR_BS);
   assign is_term  = (c == CHR_CR) || (c == CHR_LF);
   assign is_esc   = (c == CHR_ESC);
   assign is_arrow = (c == CHR_A) || (c == CHR_B) || (c == CHR_C) || (c == CHR_D);
   assign store_en = (is_print || is_bs || is_term) && !esc_ff;
   assign wi_inc   = wi_ff + IDX_W'(store_en);
   assign commit   = is_term && !pend_ff && (wi_inc > IDX_W'(1)) && !esc_ff;

   always_comb begin
      wi_a     = wi_inc;
      esc_nx   = esc_ff;
      brk_nx   = brk_ff;
      has_echo = 1'b0;
      if (is_bs) begin
         if ((wi_inc >= IDX_W'(2)) && !esc_ff) begin
            wi_a     = wi_inc - IDX_W'(2);
            has_echo = 1'b1;
         end else begin
            wi_a = '0;
         end
      end else if (is_term) begin
         if (commit) begin
            wi_a = '0;
         end
      end else if (is_esc) begin
         esc_nx = 1'b1;
      end else if (esc_ff) begin
         if (brk_ff) begin
            if (is_arrow) begin
               esc_nx = 1'b0;
               brk_nx = 1'b0;
            end
         end else if (c == CHR_LBRACKET) begin
            brk_nx = 1'b1;
         end
      end else begin
         has_echo = 1'b1;
      end
      ovf   = (wi_a >= IDX_W'(LINE_WIDTH));
      wi_nx = ovf ? '0 : wi_a;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign echo_last = bs_ff ? 2'd2 : 2'd0;

   always_comb begin
      state_in     = state_ff;
      wi_in        = wi_ff;
      esc_in       = esc_ff;
      brk_in       = brk_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ptr_in       = ptr_ff;
      line_last_in = line_last_ff;
      pos_in       = pos_ff;
      bs_in        = bs_ff;
      echo_byte_in = echo_byte_ff;
      notice_in    = notice_ff;
      ram_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ptr_in = '0;
            if (req_valid) begin
               if (req.opcode == OP_RELEASE) begin
                  pend_in = 1'b0;
               end else begin
                  ram_we       = store_en;
                  wi_in        = wi_nx;
                  esc_in       = esc_nx;
                  brk_in       = brk_nx;
                  pend_in      = pend_ff || commit;
                  line_last_in = ADDR_W'(wi_inc - IDX_W'(2));
                  echo_byte_in = c;
                  bs_in        = is_bs;
                  notice_in    = ovf;
                  pos_in       = 2'd0;
                  if (has_echo) begin
                     state_in = ST_ECHO;
                  end else if (commit) begin
                     state_in = ST_LINE;
                  end else if (ovf) begin
                     state_in = ST_NOTICE;
                  end
               end
            end
         end
         ST_ECHO: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_ECHO;
               rsp_in.out_byte = (bs_ff && (pos_ff == 2'd1)) ? CHR_SPACE : echo_byte_ff;
               rsp_in.last     = (pos_ff == echo_last) && !notice_ff;
               if (pos_ff == echo_last) begin
                  state_in = notice_ff ? ST_NOTICE : ST_IDLE;
               end else begin
                  pos_in = pos_ff + 2'd1;
               end
            end
         end
         ST_LINE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_LINE;
               rsp_in.out_byte = ram_rd;
               rsp_in.last     = (ptr_ff == line_last_ff);
               if (ptr_ff == line_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + ADDR_W'(1);
               end
            end
         end
         ST_NOTICE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_NOTICE;
               rsp_in.out_byte = 8'h00;
               rsp_in.last     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wi_ff        <= '0;
         esc_ff       <= 1'b0;
         brk_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wi_ff        <= wi_in;
         esc_ff       <= esc_in;
         brk_ff       <= brk_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      ptr_ff       <= ptr_in;
      line_last_ff <= line_last_in;
      pos_ff       <= pos_in;
      bs_ff        <= bs_in;
      echo_byte_ff <= echo_byte_in;
      notice_ff    <= notice_in;
   end

   cle_ram #(.WIDTH(8), .DEPTH(LINE_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wi_ff[ADDR_W-1:0]),
      .wr_data (c),
      .rd_addr (ptr_in),
      .rd_data (ram_rd));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ sv/cle_checker.sv @@
`include "console_line_editor_assert.svh"

module cle_checker
   import cle_pkg::*;
   (input logic    clock,
    input logic    reset,
    input logic    req_ready,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input rsp_type rsp);

   `CLE_ASSERT_NOW(a_busy_mid_request, rsp_valid && !rsp.last, !req_ready,
      "request taken mid-sequence")
   `CLE_ASSERT_NOW(a_notice_form, rsp_valid && (rsp.kind == KIND_NOTICE),
      (rsp.out_byte == 8'h00) && rsp.last, "bad overflow notice")
   `CLE_ASSERT_NOW(a_kind_code, rsp_valid,
      (rsp.kind == KIND_ECHO) || (rsp.kind == KIND_LINE) || (rsp.kind == KIND_NOTICE),
      "bad response kind")
   `CLE_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);
